>>> rtl/ppfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types and constants for the pulse period frequency classifier.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  // input actions
  typedef enum logic [1:0] {
    ACT_CAPTURE = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_REARM   = 2'd3
  } action_t;

  // configuration register indexes
  localparam int          CFG_IW       = 2;
  localparam int          CFG_DW       = 16;
  localparam logic [1:0]  REG_ENABLE   = 2'd0;
  localparam logic [1:0]  REG_OWN_MASK = 2'd1;
  localparam logic [1:0]  REG_TOL      = 2'd2;
  localparam logic [1:0]  REG_LIMIT    = 2'd3;

  // reset values
  localparam logic [7:0]  TOL_RST      = 8'd8;
  localparam logic [7:0]  LIMIT_RST    = 8'd4;

  // targets reachable by the mask and the reported index
  localparam int          TGT_SPAN     = 16;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        clear;
    logic        load;
    logic [3:0]  load_idx;
    logic [31:0] load_val;
    logic [7:0]  tol;
    logic [7:0]  limit;
  } cell_ctl_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        found;
    logic        over;
    logic        high;     // matched target index is 16 or more
    logic [3:0]  idx;
    logic [31:0] period;
  } tok_t;

endpackage

>>> rtl/ppfc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_div
// Divider by a constant through reciprocal multiplication; the dividend is
// registered at start, then the product, and done rises with the product.
// ----------------------------------------------------------------------------
module ppfc_div #(
  parameter int DIVISOR = 40000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  // floor(x / DIVISOR) == floor(x * RECIP / 2^SHIFT) for every 32-bit x,
  // with SHIFT = 32 + ceil(log2(DIVISOR)) and RECIP = ceil(2^SHIFT / DIVISOR)
  localparam int          SHIFT    = 32 + $clog2(DIVISOR);
  localparam logic [63:0] RECIP    = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                     / 64'(DIVISOR);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic        RECIP_HI = RECIP[32];

  logic [31:0] dvd_r;
  logic [64:0] prod_r, prod_nxt;
  logic [63:0] prod_lo;
  logic        run_r;
  logic        done_r;

  // RECIP has at most 33 bits: a 32 x 32 product plus a shifted copy
  assign prod_lo  = 64'(dvd_r) * 64'(RECIP_LO);
  assign prod_nxt = {1'b0, prod_lo} + (RECIP_HI ? {1'b0, dvd_r, 32'd0} : 65'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= start;
      done_r <= run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (run_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = 32'(prod_r >> SHIFT);

endmodule

>>> rtl/ppfc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_cell
// One target slot: holds a target period and its hit counter, checks the
// passing token and hands it to the next cell.
// ----------------------------------------------------------------------------
module ppfc_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppfc_pkg::cell_ctl_t ctl,
  input  ppfc_pkg::tok_t      tok_i,
  output ppfc_pkg::tok_t      tok_o
);

  logic [31:0]    target_r;
  logic [7:0]     hit_r;
  logic           tok_valid_r;
  ppfc_pkg::tok_t tok_r, tok_nxt;

  logic [32:0] hi_bound;
  logic [31:0] lo_bound;
  logic        hit;
  logic        take;
  logic [7:0]  hit_inc;
  logic        load_me;

  assign hi_bound = {1'b0, target_r} + {25'd0, ctl.tol};
  // lower bound saturates at zero
  assign lo_bound = (target_r > {24'd0, ctl.tol}) ? (target_r - {24'd0, ctl.tol}) : 32'd0;
  assign hit      = ({1'b0, tok_i.period} <= hi_bound) && (tok_i.period >= lo_bound);
  assign take     = tok_i.valid && !tok_i.found && hit;
  assign hit_inc  = hit_r + 8'd1;
  assign load_me  = ctl.load && (IDX < ppfc_pkg::TGT_SPAN) && (32'(ctl.load_idx) == IDX);

  always_comb begin
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.over  = (hit_inc > ctl.limit);
      tok_nxt.high  = (IDX >= ppfc_pkg::TGT_SPAN);
      tok_nxt.idx   = 4'(IDX % ppfc_pkg::TGT_SPAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_i.valid;
      if (ctl.clear) begin
        hit_r <= '0;
      end else if (take) begin
        hit_r <= hit_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_me) begin
      target_r <= ctl.load_val;
    end
    tok_r <= tok_nxt;
  end

  always_comb begin
    tok_o       = tok_r;
    tok_o.valid = tok_valid_r;
  end

endmodule

>>> rtl/pulse_period_frequency_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_period_frequency_classifier
// Turns per-sensor timer captures into scaled periods and matches them
// against a row of target cells, counting hits and reporting detections.
// ----------------------------------------------------------------------------
//  channel | handshake           | word
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | action sensor capture_time table_index
//          |                     | table_value
//  out     | out_valid/out_stall | matched detected freq_index restart_timer
//          |                     | stop_timer
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data (always ready)
//
// A counted capture passes from one acceptance to the next through accept,
// the scale multiply, the reciprocal divide, the token walk through the cell
// row one cell per cycle, and hand-off. Timeout, load, re-arm, ignored
// captures and captures with counting off go from accept straight to
// hand-off. One word is in work at a time; the next is accepted while
// the previous result waits in the output register, and the hand-off waits
// while that register holds a stalled word. Reset is synchronous.
// ----------------------------------------------------------------------------
module pulse_period_frequency_classifier #(
  parameter int NUM_SENSORS = 4,
  parameter int NUM_TARGETS = 16,
  parameter int SCALE_MULT  = 1000,
  parameter int SCALE_DIV   = 40000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [1:0]                    in_sensor,
  input  logic [31:0]                   in_capture_time,
  input  logic [3:0]                    in_table_index,
  input  logic [31:0]                   in_table_value,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_matched,
  output logic                          out_detected,
  output logic [3:0]                    out_freq_index,
  output logic                          out_restart_timer,
  output logic                          out_stop_timer,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppfc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ppfc_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int          SIW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam logic [31:0] MULT32 = 32'(SCALE_MULT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SCAN,
    S_PUT
  } state_t;

  state_t      state_r;
  logic        armed_r;
  logic        enable_r;
  logic [15:0] own_mask_r;
  logic [7:0]  tol_r;
  logic [7:0]  limit_r;
  logic [31:0] last_r [NUM_SENSORS];
  logic [31:0] diff_r;

  logic        res_matched_r, res_detected_r, res_restart_r;
  logic [3:0]  res_index_r;

  logic        out_valid_r;
  logic        out_matched_r, out_detected_r, out_restart_r;
  logic [3:0]  out_index_r;

  logic                in_acc;
  ppfc_pkg::action_t   act;
  logic                sensor_ok;
  logic                capture_run;
  logic [SIW-1:0]      sidx;
  logic [31:0]         prod;
  logic                div_done;
  logic [31:0]         div_quot;
  logic                tail_over;
  logic                owned;
  logic                out_free;
  logic                put_fire;
  ppfc_pkg::cell_ctl_t cell_ctl;
  ppfc_pkg::tok_t      chain [NUM_TARGETS + 1];

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && (state_r == S_IDLE);
  assign act         = ppfc_pkg::action_t'(in_action);
  assign sensor_ok   = (32'(in_sensor) < NUM_SENSORS);
  assign capture_run = (act == ppfc_pkg::ACT_CAPTURE) && armed_r && sensor_ok && enable_r;
  assign sidx        = SIW'(in_sensor);
  assign prod        = diff_r * MULT32;   // wraps at 32 bits
  assign out_free    = !out_valid_r || !out_stall;
  assign put_fire    = (state_r == S_PUT) && out_free;
  assign cfg_ready   = 1'b1;

  ppfc_div #(
    .DIVISOR (SCALE_DIV)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_MUL),
    .dividend (prod),
    .done     (div_done),
    .quotient (div_quot)
  );

  // token enters the row as the quotient lands
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = (state_r == S_DIV) && div_done;
    chain[0].period = div_quot;
  end

  assign tail_over = chain[NUM_TARGETS].valid && chain[NUM_TARGETS].found
                     && chain[NUM_TARGETS].over;
  assign owned     = !chain[NUM_TARGETS].high && own_mask_r[chain[NUM_TARGETS].idx];

  always_comb begin
    cell_ctl          = '0;
    cell_ctl.tol      = tol_r;
    cell_ctl.limit    = limit_r;
    cell_ctl.load     = in_acc && (act == ppfc_pkg::ACT_LOAD);
    cell_ctl.load_idx = in_table_index;
    cell_ctl.load_val = in_table_value;
    cell_ctl.clear    = (in_acc && (act == ppfc_pkg::ACT_TIMEOUT))
                        || ((state_r == S_SCAN) && tail_over);
  end

  for (genvar g = 0; g < NUM_TARGETS; g++) begin : g_cell
    ppfc_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl),
      .tok_i (chain[g]),
      .tok_o (chain[g + 1])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      own_mask_r <= '0;
      tol_r      <= ppfc_pkg::TOL_RST;
      limit_r    <= ppfc_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppfc_pkg::REG_ENABLE:   enable_r   <= cfg_data[0];
        ppfc_pkg::REG_OWN_MASK: own_mask_r <= cfg_data[15:0];
        ppfc_pkg::REG_TOL:      tol_r      <= cfg_data[7:0];
        ppfc_pkg::REG_LIMIT:    limit_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // control, state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b1;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SENSORS; s++) begin
        last_r[s] <= '0;
      end
    end else begin
      out_valid_r <= put_fire || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_matched_r  <= 1'b0;
            res_detected_r <= 1'b0;
            res_restart_r  <= 1'b0;
            res_index_r    <= '0;
            state_r        <= capture_run ? S_MUL : S_PUT;
            case (act)
              ppfc_pkg::ACT_CAPTURE: begin
                if (armed_r && sensor_ok) begin
                  diff_r       <= in_capture_time - last_r[sidx];
                  last_r[sidx] <= in_capture_time;
                end
              end
              ppfc_pkg::ACT_TIMEOUT: armed_r <= 1'b1;
              ppfc_pkg::ACT_REARM:   armed_r <= 1'b1;
              default: ;
            endcase
          end
        end
        S_MUL: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[NUM_TARGETS].valid) begin
            state_r <= S_PUT;
            if (chain[NUM_TARGETS].found) begin
              res_matched_r <= 1'b1;
              res_index_r   <= chain[NUM_TARGETS].idx;
              if (chain[NUM_TARGETS].over) begin
                if (!owned) begin
                  res_detected_r <= 1'b1;
                  armed_r        <= 1'b0;
                end
              end else begin
                res_restart_r <= 1'b1;
              end
            end
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_matched_r  <= res_matched_r;
            out_detected_r <= res_detected_r;
            out_restart_r  <= res_restart_r;
            out_index_r    <= res_index_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_detected      = out_detected_r;
  assign out_freq_index    = out_index_r;
  assign out_restart_timer = out_restart_r;
  assign out_stop_timer    = out_detected_r;

endmodule
